FILE: rtl/gap_linear_interpolator_top_macros.svh
// Assertion helpers used by the interpolator datapath.
`ifndef GAP_LINEAR_INTERPOLATOR_TOP_MACROS_SVH
`define GAP_LINEAR_INTERPOLATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gli_pkg.sv
`timescale 1ns / 1ps
package gli_pkg;

	localparam int GLI_GAP_DEPTH = 64;
	localparam int TIME_W        = 48;
	localparam int VALUE_W       = 32;
	localparam int PROD_W        = 81;
	localparam int QUO_W         = 35;
	localparam logic [QUO_W-1:0] QCAP = 35'h4_0000_0000;

	typedef struct packed {
		logic [TIME_W-1:0]         sample_time;
		logic signed [VALUE_W-1:0] sample_value;
		logic                      is_missing;
	} in_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]         point_time;
		logic signed [VALUE_W-1:0] predicted_value;
		logic signed [VALUE_W-1:0] true_value;
		logic [63:0]               squared_error;
		logic [63:0]               error_total;
		logic [31:0]               missing_total;
		logic                      overflowed;
		logic                      last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_OFF,
		ST_MLO,
		ST_MHI,
		ST_DINIT,
		ST_DIV,
		ST_PRED,
		ST_ERR,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic store;
		logic anchor;
		logic start;
		logic off;
		logic mlo;
		logic mhi;
		logic dinit;
		logic div_step;
		logic pred;
		logic err;
		logic emit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic gap_pending;
		logic div_last;
		logic idx_last;
		logic out_free;
	} status_t;

endpackage

FILE: rtl/gli_stream_if.sv
`timescale 1ns / 1ps
interface gli_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/gli_ram.sv
`timescale 1ns / 1ps
module gli_ram #(
	parameter int Width = 8,
	parameter int Depth = 64,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/gli_ctrl.sv
`timescale 1ns / 1ps
module gli_ctrl import gli_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_missing,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_missing) begin
						cmd.store = 1'b1;
					end else if (status.gap_pending) begin
						cmd.start = 1'b1;
						state_d   = ST_READ;
					end else begin
						cmd.anchor = 1'b1;
					end
				end
			end
			ST_READ:  state_d = ST_OFF;
			ST_OFF: begin
				cmd.off = 1'b1;
				state_d = ST_MLO;
			end
			ST_MLO: begin
				cmd.mlo = 1'b1;
				state_d = ST_MHI;
			end
			ST_MHI: begin
				cmd.mhi = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.dinit = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_PRED;
				end
			end
			ST_PRED: begin
				cmd.pred = 1'b1;
				state_d  = ST_ERR;
			end
			ST_ERR: begin
				cmd.err = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.idx_last) begin
						cmd.finish = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

FILE: rtl/gli_datapath.sv
`timescale 1ns / 1ps
`include "gap_linear_interpolator_top_macros.svh"
module gli_datapath import gli_pkg::*; #(
	parameter int GAP_DEPTH = GLI_GAP_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  sample,
	input  cmd_t      cmd,
	output status_t   status,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	localparam int AW = (GAP_DEPTH > 1) ? $clog2(GAP_DEPTH) : 1;
	localparam int CW = $clog2(GAP_DEPTH + 1);
	localparam int EW = TIME_W + VALUE_W;

	// Anchor and gap bookkeeping.
	logic [TIME_W-1:0]         left_time_q;
	logic signed [VALUE_W-1:0] left_value_q;
	logic                      gap_open_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic [63:0]               err_sum_q;
	logic [31:0]               miss_q;
	logic                      ovf_q;
	logic                      out_valid_q;

	// Per-run and per-point working registers.
	logic [TIME_W-1:0]         right_time_q;
	logic signed [VALUE_W-1:0] right_value_q;
	logic [TIME_W-1:0]         dx_mag_q;
	logic                      dx_neg_q;
	logic [32:0]               dy_mag_q;
	logic                      dy_neg_q;
	logic [TIME_W-1:0]         off_mag_q;
	logic                      neg_q;
	logic [TIME_W-1:0]         pt_time_q;
	logic signed [VALUE_W-1:0] pt_val_q;
	logic [56:0]               plo_q;
	logic [PROD_W-1:0]         prod_q;
	logic [TIME_W-1:0]         rem_q;
	logic [QUO_W-1:0]          quo_q;
	logic                      cap_q;
	logic [5:0]                bit_q;
	logic signed [VALUE_W-1:0] pred_q;
	logic [63:0]               sq_q;
	out_item_t                 out_q;

	logic [EW-1:0]     ram_rdata;
	logic              ram_we;
	logic [TIME_W:0]   dx_full, off_full;
	logic [32:0]       dy_full;
	logic [56:0]       phi;
	logic [TIME_W:0]   r2;
	logic              r2_ge;
	logic [QUO_W-1:0]  qeff;
	logic signed [36:0] psum;
	logic signed [32:0] e_full;
	logic [32:0]       e_mag;
	logic [64:0]       sum65;
	logic [63:0]       sum_sat;
	logic [QUO_W-1:0]  low_bits;

	assign ram_we = cmd.store && (count_q < CW'(GAP_DEPTH));

	gli_ram #(.Width(EW), .Depth(GAP_DEPTH)) u_gap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata ({sample.sample_time, sample.sample_value}),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		dx_full  = {1'b0, sample.sample_time} - {1'b0, left_time_q};
		dy_full  = {sample.sample_value[VALUE_W-1], sample.sample_value}
			- {left_value_q[VALUE_W-1], left_value_q};
		off_full = {1'b0, ram_rdata[EW-1:VALUE_W]} - {1'b0, left_time_q};
		phi      = 57'(dy_mag_q) * 57'(off_mag_q[47:24]);
		low_bits = prod_q[QUO_W-1:0];
		r2       = {rem_q, low_bits[bit_q]};
		r2_ge    = r2 >= {1'b0, dx_mag_q};
		qeff     = (cap_q || (quo_q > QCAP)) ? QCAP : quo_q;
		psum     = neg_q ? (37'(left_value_q) - $signed({2'b0, qeff}))
			: (37'(left_value_q) + $signed({2'b0, qeff}));
		e_full   = 33'(pred_q) - 33'(pt_val_q);
		e_mag    = e_full[32] ? (33'd0 - e_full) : e_full;
		sum65    = {1'b0, err_sum_q} + {1'b0, sq_q};
		sum_sat  = sum65[64] ? '1 : sum65[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_time_q  <= '0;
			left_value_q <= '0;
			gap_open_q   <= 1'b0;
			count_q      <= '0;
			idx_q        <= '0;
			err_sum_q    <= '0;
			miss_q       <= '0;
			ovf_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			bit_q        <= '0;
		end else begin
			if (cmd.store) begin
				gap_open_q <= 1'b1;
				if (miss_q != '1) begin
					miss_q <= miss_q + 32'd1;
				end
				if (ram_we) begin
					count_q <= count_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.anchor) begin
				left_time_q  <= sample.sample_time;
				left_value_q <= sample.sample_value;
			end
			if (cmd.start) begin
				idx_q <= '0;
			end
			if (cmd.dinit) begin
				bit_q <= 6'(QUO_W - 1);
			end
			if (cmd.div_step) begin
				bit_q <= bit_q - 6'd1;
			end
			if (cmd.emit) begin
				err_sum_q <= sum_sat;
				idx_q     <= idx_q + CW'(1);
			end
			if (cmd.finish) begin
				left_time_q  <= right_time_q;
				left_value_q <= right_value_q;
				gap_open_q   <= 1'b0;
				count_q      <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			right_time_q  <= sample.sample_time;
			right_value_q <= sample.sample_value;
			dx_neg_q      <= dx_full[TIME_W];
			dx_mag_q      <= dx_full[TIME_W] ? (TIME_W'(0) - dx_full[TIME_W-1:0])
				: dx_full[TIME_W-1:0];
			dy_neg_q      <= dy_full[32];
			dy_mag_q      <= dy_full[32] ? (33'd0 - dy_full) : dy_full;
		end
		if (cmd.off) begin
			pt_time_q <= ram_rdata[EW-1:VALUE_W];
			pt_val_q  <= ram_rdata[VALUE_W-1:0];
			off_mag_q <= off_full[TIME_W] ? (TIME_W'(0) - off_full[TIME_W-1:0])
				: off_full[TIME_W-1:0];
			neg_q     <= dy_neg_q ^ off_full[TIME_W] ^ dx_neg_q;
		end
		if (cmd.mlo) begin
			plo_q <= 57'(dy_mag_q) * 57'(off_mag_q[23:0]);
		end
		if (cmd.mhi) begin
			prod_q <= {phi, 24'd0} + {24'd0, plo_q};
		end
		if (cmd.dinit) begin
			// A quotient of 2^35 or more is past the cap, so only 35 bits are formed.
			rem_q <= {2'b0, prod_q[PROD_W-1:QUO_W]};
			cap_q <= {2'b0, prod_q[PROD_W-1:QUO_W]} >= dx_mag_q;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= r2_ge ? TIME_W'(r2 - {1'b0, dx_mag_q}) : r2[TIME_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], r2_ge};
		end
		if (cmd.pred) begin
			if (dx_mag_q == '0) begin
				pred_q <= left_value_q;
			end else if (psum > 37'sh0_7FFF_FFFF) begin
				pred_q <= 32'sh7FFF_FFFF;
			end else if (psum < -37'sh0_8000_0000) begin
				pred_q <= 32'sh8000_0000;
			end else begin
				pred_q <= psum[VALUE_W-1:0];
			end
		end
		if (cmd.err) begin
			sq_q <= 64'(e_mag[31:0]) * 64'(e_mag[31:0]);
		end
		if (cmd.emit) begin
			out_q.point_time      <= pt_time_q;
			out_q.predicted_value <= pred_q;
			out_q.true_value      <= pt_val_q;
			out_q.squared_error   <= sq_q;
			out_q.error_total     <= sum_sat;
			out_q.missing_total   <= miss_q;
			out_q.overflowed      <= ovf_q;
			out_q.last            <= status.idx_last;
		end
	end

	assign status.gap_pending = gap_open_q && (count_q != '0);
	assign status.div_last    = (bit_q == 6'd0);
	assign status.idx_last    = ((idx_q + CW'(1)) == count_q);
	assign status.out_free    = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign out_data           = out_q;

	`GLI_ASSERT_NOW(a_start_nonempty, clk, arst_n, cmd.start, count_q != '0, "run started on empty gap")
	`GLI_ASSERT_NEXT(a_finish_clears, clk, arst_n, cmd.finish, (count_q == '0) && !gap_open_q, "gap not cleared after run")
	`GLI_ASSERT_NOW(a_emit_in_range, clk, arst_n, cmd.emit, idx_q < count_q, "emitted point beyond buffered count")
	`GLI_ASSERT_NEXT(a_ovf_sticky, clk, arst_n, ovf_q, ovf_q, "overflow flag cleared")
endmodule

FILE: rtl/gap_linear_interpolator_top.sv
`timescale 1ns / 1ps
// Gap-filling linear interpolator. Samples arrive as transfers on sample_in,
// each with a 48-bit time, a signed Q16.16 value and a missing mark. A missing
// sample is stored in a buffer of GAP_DEPTH entries; once the buffer is full,
// further missing samples are dropped and the sticky overflowed flag is set. A
// good sample that closes a gap yields one transfer on result_out for every
// buffered point, in arrival order, each predicted on the line from the
// previous good sample (time 0, value 0 after reset) to the closing one;
// the final result of the run carries last. Each buffered point goes through
// buffer read, offset, two half-width multiplies, divider setup, the bit-serial
// divider that forms one quotient bit per cycle, prediction, squaring and the
// result register; the block takes no new sample until the run's last result
// has been loaded into the output register.
module gap_linear_interpolator_top import gli_pkg::*; #(
	parameter int GAP_DEPTH = GLI_GAP_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	gli_stream_if.sink   sample_in,
	gli_stream_if.source result_out
);
	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign sample_in.ready = in_ready;

	// Sequencer: one state per step of the per-point work.
	gli_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample_in.valid),
		.in_missing (sample_in.data.is_missing),
		.in_ready   (in_ready),
		.status     (status),
		.cmd        (cmd)
	);

	// Datapath: gap buffer, anchors, multiplier, divider and output register.
	gli_datapath #(.GAP_DEPTH(GAP_DEPTH)) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_in.data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.out_data  (result_out.data)
	);
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Testbench for the gap-filling linear interpolator. Samples are sent as
// transfers on sample_in; every result transfer on result_out is checked
// field by field against a predictor that tracks the anchor, the gap buffer,
// the error sum, the missing count and the overflow flag.
module tb;
	import gli_pkg::*;

	localparam int DEPTH = GLI_GAP_DEPTH;
	localparam longint unsigned CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gli_stream_if #(.T(in_item_t)) sample_in ();
	gli_stream_if #(.T(out_item_t)) result_out ();

	gap_linear_interpolator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_in(sample_in.sink),
		.result_out(result_out.source)
	);

	always #5 clk = ~clk;

	// Predictor state, kept at the block's widths.
	logic [47:0] anchor_time;
	logic signed [31:0] anchor_value;
	logic gap_is_open;
	logic [47:0] buf_time [DEPTH];
	logic signed [31:0] buf_value [DEPTH];
	int unsigned buf_fill;
	logic [63:0] err_acc;
	logic [31:0] miss_acc;
	logic ovf_seen;

	out_item_t pending_results [$];
	int unsigned mismatches = 0;
	longint unsigned cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit long_hold = 1'b0;

	// Directed table: fields, plus an expected first result where obvious.
	typedef struct {
		in_item_t item;
		bit has_expect;
		logic signed [31:0] exp_pred;
	} table_row_t;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h", what, got, want);
		mismatches++;
	endtask

	// Prediction of a buffered point on the line from the anchor to the closing
	// sample; the quotient is truncated toward zero and the sum saturated.
	function automatic logic signed [31:0] interpolate(input logic [47:0] tp,
			input logic [47:0] tr, input logic signed [31:0] vr);
		logic signed [49:0] dx, off;
		logic signed [33:0] dy;
		logic [49:0] mdx, moff;
		logic [33:0] mdy;
		logic [83:0] prod, quo;
		logic [34:0] q;
		logic neg;
		logic signed [37:0] p;
		dx = $signed({2'b00, tr}) - $signed({2'b00, anchor_time});
		off = $signed({2'b00, tp}) - $signed({2'b00, anchor_time});
		dy = 34'(vr) - 34'(anchor_value);
		if (dx == 0)
			return anchor_value;
		neg = ((dy < 0) != (off < 0)) != (dx < 0);
		mdx = dx < 0 ? -dx : dx;
		moff = off < 0 ? -off : off;
		mdy = dy < 0 ? -dy : dy;
		prod = 84'(mdy) * 84'(moff);
		quo = prod / 84'(mdx);
		q = quo > 84'(QCAP) ? QCAP : quo[34:0];
		p = neg ? 38'(anchor_value) - 38'(q) : 38'(anchor_value) + 38'(q);
		if (p > 38'sd2147483647)
			return 32'sh7fffffff;
		if (p < -38'sd2147483648)
			return 32'sh80000000;
		return p[31:0];
	endfunction

	// Applies one accepted sample to the predictor and queues its results.
	task automatic predict_sample(input in_item_t s);
		out_item_t r;
		logic signed [32:0] e;
		logic [31:0] m;
		logic [63:0] sq;
		if (s.is_missing) begin
			if (buf_fill < DEPTH) begin
				buf_time[buf_fill] = s.sample_time;
				buf_value[buf_fill] = s.sample_value;
				buf_fill++;
			end else begin
				ovf_seen = 1'b1;
			end
			if (miss_acc != 32'hffffffff)
				miss_acc++;
			gap_is_open = 1'b1;
			return;
		end
		if (gap_is_open) begin
			for (int i = 0; i < buf_fill; i++) begin
				r.point_time = buf_time[i];
				r.predicted_value = interpolate(buf_time[i], s.sample_time, s.sample_value);
				r.true_value = buf_value[i];
				e = 33'(r.predicted_value) - 33'(buf_value[i]);
				m = e < 0 ? 32'(-e) : 32'(e);
				sq = 64'(m) * 64'(m);
				err_acc = (err_acc > ~sq) ? '1 : err_acc + sq;
				r.squared_error = sq;
				r.error_total = err_acc;
				r.missing_total = miss_acc;
				r.overflowed = ovf_seen;
				r.last = (i + 1 == buf_fill);
				pending_results.push_back(r);
			end
		end
		anchor_time = s.sample_time;
		anchor_value = s.sample_value;
		gap_is_open = 1'b0;
		buf_fill = 0;
	endtask

	// Drives one sample at the falling edge and waits for its transfer. Valid
	// stays up after the transfer; the next falling-edge action either drives
	// the next sample or drops valid.
	task automatic send_sample(input in_item_t s);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			sample_in.valid <= 1'b0;
			@(negedge clk);
		end
		sample_in.valid <= 1'b1;
		sample_in.data <= s;
		@(posedge clk);
		while (!sample_in.ready)
			@(posedge clk);
		predict_sample(s);
		@(negedge clk);
	endtask

	function automatic in_item_t random_sample(input bit missing);
		in_item_t s;
		s.sample_time = 48'({$urandom, $urandom});
		s.sample_value = $urandom;
		s.is_missing = missing;
		return s;
	endfunction

	function automatic in_item_t make_sample(input logic [47:0] t,
			input logic [31:0] v, input logic m);
		in_item_t s;
		s.sample_time = t;
		s.sample_value = v;
		s.is_missing = m;
		return s;
	endfunction

	// A gap: a run of missing samples closed by a good one. When ordered, times do
	// not decrease from a random base so that the line interpolates; else random.
	task automatic send_gap(input int len, input bit ordered);
		logic [47:0] t;
		t = ordered ? 48'({$urandom_range(65535), $urandom}) : 48'({$urandom, $urandom});
		for (int i = 0; i < len; i++) begin
			t = ordered ? t + 48'($urandom_range(1000)) : 48'({$urandom, $urandom});
			send_sample(make_sample(t, $urandom, 1'b1));
		end
		t = ordered ? t + 48'($urandom_range(1000)) : 48'({$urandom, $urandom});
		send_sample(make_sample(t, $urandom, 1'b0));
	endtask

	task automatic wait_drained();
		sample_in.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	// Result side: ready is driven at the falling edge, transfers are taken
	// at the rising edge and compared with the oldest expectation.
	initial begin
		result_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold)
				result_out.ready <= 1'b0;
			else
				result_out.ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 64'(result_out.data.point_time), 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (result_out.data.point_time !== want.point_time)
					report_mismatch("point_time", 64'(result_out.data.point_time),
						64'(want.point_time));
				if (result_out.data.predicted_value !== want.predicted_value)
					report_mismatch("predicted_value", 64'(result_out.data.predicted_value),
						64'(want.predicted_value));
				if (result_out.data.true_value !== want.true_value)
					report_mismatch("true_value", 64'(result_out.data.true_value),
						64'(want.true_value));
				if (result_out.data.squared_error !== want.squared_error)
					report_mismatch("squared_error", result_out.data.squared_error,
						want.squared_error);
				if (result_out.data.error_total !== want.error_total)
					report_mismatch("error_total", result_out.data.error_total,
						want.error_total);
				if (result_out.data.missing_total !== want.missing_total)
					report_mismatch("missing_total", 64'(result_out.data.missing_total),
						64'(want.missing_total));
				if (result_out.data.overflowed !== want.overflowed)
					report_mismatch("overflowed", 64'(result_out.data.overflowed),
						64'(want.overflowed));
				if (result_out.data.last !== want.last)
					report_mismatch("last", 64'(result_out.data.last), 64'(want.last));
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Long receiver hold-off while the sender keeps offering samples.
	initial begin
		@(posedge arst_n);
		wait (cycle_count > 5000);
		long_hold = 1'b1;
		repeat (3000) @(posedge clk);
		long_hold = 1'b0;
	end

	table_row_t directed [13];

	initial begin
		int sent;
		int len;
		table_row_t row;
		sample_in.valid = 1'b0;
		sample_in.data = '0;
		anchor_time = '0;
		anchor_value = '0;
		gap_is_open = 1'b0;
		buf_fill = 0;
		err_acc = '0;
		miss_acc = '0;
		ovf_seen = 1'b0;

		directed = '{
			// Gap before any good sample: anchor is (0,0), so t=10 between 0 and 20
			// with value 2 at t=20 predicts 1.
			'{make_sample(48'd10, 32'sd7, 1'b1), 1'b0, 0},
			'{make_sample(48'd20, 32'sd2, 1'b0), 1'b1, 32'sd1},
			// Good sample with no open gap only moves the anchor.
			'{make_sample(48'd100, 32'sd0, 1'b0), 1'b0, 0},
			// Zero time step: prediction equals the left value.
			'{make_sample(48'd55, 32'sh7fffffff, 1'b1), 1'b0, 0},
			'{make_sample(48'd100, 32'sh12345678, 1'b0), 1'b1, 32'sd0},
			// Extremes of value and time, saturating prediction on extrapolation.
			'{make_sample(48'hffffffffffff, 32'sh80000000, 1'b1), 1'b0, 0},
			'{make_sample(48'h0, 32'sh80000000, 1'b1), 1'b0, 0},
			'{make_sample(48'd200, 32'sh7fffffff, 1'b0), 1'b0, 0},
			'{make_sample(48'hffffffffffff, 32'sh7fffffff, 1'b1), 1'b0, 0},
			'{make_sample(48'h0, 32'sh80000000, 1'b0), 1'b0, 0},
			// Times out of order.
			'{make_sample(48'd5000, 32'sh00010000, 1'b1), 1'b0, 0},
			'{make_sample(48'd3000, 32'shffff0000, 1'b1), 1'b0, 0},
			'{make_sample(48'd1000, 32'sh00020000, 1'b0), 1'b0, 0}
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			row = directed[i];
			if (row.has_expect) begin
				send_sample(row.item);
				if (pending_results.size() != 0 &&
						pending_results[0].predicted_value !== row.exp_pred)
					report_mismatch("directed prediction",
						64'(pending_results[0].predicted_value), 64'(row.exp_pred));
			end else begin
				send_sample(row.item);
			end
		end

		// Full buffer: the extra missing samples are dropped and set overflow.
		send_gap(DEPTH + 3, 1'b1);
		wait_drained();

		// Random part through the idling phases; the long hold-off falls here.
		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 79; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 79; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			while (sent < 75 * (phase + 1)) begin
				case ($urandom_range(9))
					0: begin
						send_sample(random_sample($urandom_range(1)));
						sent++;
					end
					1: begin
						len = $urandom_range(5);
						send_gap(len, 1'b0);
						sent += len + 1;
					end
					2: begin
						len = $urandom_range(DEPTH, 20);
						send_gap(len, 1'b1);
						sent += len + 1;
					end
					default: begin
						len = $urandom_range(4);
						send_gap(len, 1'b1);
						sent += len + 1;
					end
				endcase
			end
			wait_drained();
		end

		if (mismatches == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/gli_pkg.sv
rtl/gli_stream_if.sv
rtl/gli_ram.sv
rtl/gli_ctrl.sv
rtl/gli_datapath.sv
rtl/gap_linear_interpolator_top.sv
test/tb.sv
